>>> rtl/prqs_pkg.sv
// ----------------------------------------------------------------------------
// prqs_pkg
// Shared types and codes for the priority ready-queue scheduler.
// ----------------------------------------------------------------------------
package prqs_pkg;

    localparam int ID_W   = 4;
    localparam int PRIO_W = 6;
    localparam int STAT_W = 3;
    localparam int MAP_W  = 32;

    typedef logic [ID_W-1:0]   thread_id_t;
    typedef logic [PRIO_W-1:0] prio_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic [MAP_W-1:0]  ready_map_t;

    typedef enum logic [1:0] {
        MODE_DISPATCH = 2'd0,
        MODE_YIELD    = 2'd1,
        MODE_ADD      = 2'd2,
        MODE_DELETE   = 2'd3
    } mode_t;

    localparam status_t ST_INACTIVE = 3'd0;
    localparam status_t ST_READY    = 3'd1;
    localparam status_t ST_RUNNING  = 3'd2;

    // Configuration register indexes (word addresses).
    localparam logic REG_KERNEL_RUNNING = 1'b0;

    typedef struct packed {
        mode_t      mode;
        thread_id_t thread_id;
        logic       thread_given;
        prio_t      thread_priority;
        status_t    new_state;
    } in_item_t;

    typedef struct packed {
        thread_id_t run_id;
        logic       run_valid;
        logic       switched;
        thread_id_t preempted_id;
        logic       preempted_valid;
        ready_map_t ready_map;
    } out_item_t;

endpackage

>>> rtl/priority_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Thread scheduler with one FIFO ready queue per priority and a ready bitmap.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Contents
//  item      in         item_valid/item_ready   mode, thread, priority, state
//  result    out        result_valid/result_ready  run, preempt, ready map
//  config    in         APB psel/penable        kernel_running at address 0
//
//  Each transfer goes into an input register, is processed by one pass over
//  the queue links once the result register can take it, and lands in the
//  result register, so one item is taken per cycle unless the result register
//  stalls. The input register holds while the result register is full and
//  not taken. Reset clears all queues, links, status and the bitmap at once.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler #(
    parameter int NUM_PRIO    = 32,
    parameter int MAX_THREADS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  prqs_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output prqs_pkg::out_item_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import prqs_pkg::*;

    localparam int TW = $clog2(MAX_THREADS);
    localparam int PW = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;

    typedef logic [TW-1:0] tidx_t;
    typedef logic [PW-1:0] pidx_t;

    typedef struct packed {
        logic  vld;
        tidx_t id;
    } link_t;

    localparam link_t NIL = '{vld: 1'b0, id: '0};

    // Configuration
    logic kernel_running_reg;

    // Pipeline registers
    in_item_t  item_reg;
    logic      item_vld_reg;
    out_item_t result_reg;
    logic      result_vld_reg;

    // Scheduler state
    logic [NUM_PRIO-1:0] ready_reg,  ready_next;
    link_t               head_reg   [NUM_PRIO];
    link_t               head_next  [NUM_PRIO];
    link_t               tail_reg   [NUM_PRIO];
    link_t               tail_next  [NUM_PRIO];
    link_t               lnext_reg  [MAX_THREADS];
    link_t               lnext_next [MAX_THREADS];
    link_t               lprev_reg  [MAX_THREADS];
    link_t               lprev_next [MAX_THREADS];
    prio_t               queued_reg [MAX_THREADS];
    prio_t               queued_next[MAX_THREADS];
    status_t             status_reg [MAX_THREADS];
    status_t             status_next[MAX_THREADS];
    tidx_t               cur_reg,      cur_next;
    logic                cur_vld_reg,  cur_vld_next;
    prio_t               cur_prio_reg, cur_prio_next;

    out_item_t result_next;
    logic      advance;
    logic      fire;
    logic      cfg_write;

    assign advance    = !result_vld_reg || result_ready;
    assign fire       = item_vld_reg && advance;
    assign item_ready = !item_vld_reg || advance;

    assign result_valid = result_vld_reg;
    assign result       = result_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_KERNEL_RUNNING);
    assign prdata    = (paddr[2] == REG_KERNEL_RUNNING) ? {31'b0, kernel_running_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_running_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            kernel_running_reg <= pwdata[0];
        end
    end

    // Highest set bit of the ready bitmap.
    function automatic pidx_t top_ready(input logic [NUM_PRIO-1:0] bits);
        pidx_t top;
        top = '0;
        for (int i = 0; i < NUM_PRIO; i++)
        begin
            if (bits[i])
            begin
                top = pidx_t'(i);
            end
        end
        return top;
    endfunction

    always_comb
    begin
        logic    ok;
        logic    do_unlink;
        logic    do_append;
        tidx_t   t;
        pidx_t   aidx;
        pidx_t   uidx;
        pidx_t   top;
        prio_t   q;
        link_t   prv;
        link_t   nxt;
        link_t   tl;
        link_t   h;
        link_t   cand;
        prio_t   cprio;
        logic    have;
        logic    running;
        logic    sw;
        logic    pre;
        tidx_t   pre_id;

        ready_next    = ready_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        lnext_next    = lnext_reg;
        lprev_next    = lprev_reg;
        queued_next   = queued_reg;
        status_next   = status_reg;
        cur_next      = cur_reg;
        cur_vld_next  = cur_vld_reg;
        cur_prio_next = cur_prio_reg;

        ok = kernel_running_reg && (item_reg.thread_priority != '0) &&
             (item_reg.thread_priority <= NUM_PRIO) && (item_reg.thread_id < MAX_THREADS);
        t         = tidx_t'(item_reg.thread_id);
        aidx      = pidx_t'(item_reg.thread_priority - prio_t'(1));
        do_unlink = 1'b0;
        do_append = 1'b0;
        sw        = 1'b0;
        pre       = 1'b0;
        pre_id    = '0;
        uidx      = '0;
        q         = '0;
        prv       = NIL;
        nxt       = NIL;
        tl        = NIL;
        h         = head_reg[aidx];
        top       = top_ready(ready_reg);
        cand      = NIL;
        cprio     = '0;
        have      = 1'b0;
        running   = 1'b0;

        if (ok)
        begin
            case (item_reg.mode)
                MODE_DISPATCH:
                begin
                    if (item_reg.thread_given)
                    begin
                        cand  = '{vld: 1'b1, id: t};
                        cprio = item_reg.thread_priority;
                        have  = 1'b1;
                    end
                    else
                    begin
                        cand  = head_reg[top];
                        cprio = prio_t'(top) + prio_t'(1);
                        have  = (ready_reg != '0) && cand.vld;
                    end
                    running = cur_vld_reg && (status_reg[cur_reg] == ST_RUNNING);
                    if (have && (!running || (cprio > cur_prio_reg)))
                    begin
                        if (running)
                        begin
                            status_next[cur_reg] = ST_READY;
                            pre    = 1'b1;
                            pre_id = cur_reg;
                        end
                        status_next[cand.id] = ST_RUNNING;
                        cur_next      = cand.id;
                        cur_vld_next  = 1'b1;
                        cur_prio_next = cprio;
                        sw            = 1'b1;
                    end
                end
                MODE_YIELD:
                begin
                    // Only a queue with at least two threads rotates.
                    if (h.vld && lnext_reg[h.id].vld)
                    begin
                        do_unlink = 1'b1;
                        do_append = 1'b1;
                    end
                end
                MODE_ADD:
                begin
                    do_unlink = 1'b1;
                    do_append = 1'b1;
                end
                default:
                begin
                    do_unlink = 1'b1;
                end
            endcase
        end

        if (do_unlink)
        begin
            q = queued_reg[t];
            if ((q != '0) && (q <= NUM_PRIO))
            begin
                uidx = pidx_t'(q - prio_t'(1));
                prv  = lprev_reg[t];
                nxt  = lnext_reg[t];
                if (prv.vld)
                begin
                    lnext_next[prv.id] = nxt;
                end
                else
                begin
                    head_next[uidx] = nxt;
                end
                if (nxt.vld)
                begin
                    lprev_next[nxt.id] = prv;
                end
                else
                begin
                    tail_next[uidx] = prv;
                end
                if (!head_next[uidx].vld)
                begin
                    head_next[uidx]  = NIL;
                    tail_next[uidx]  = NIL;
                    ready_next[uidx] = 1'b0;
                end
                lnext_next[t] = NIL;
                lprev_next[t] = NIL;
            end
            queued_next[t] = '0;

            if (do_append)
            begin
                status_next[t] = ST_READY;
            end
            else
            begin
                // Ready delete stores the given state and keeps the bitmap exact.
                status_next[t] = item_reg.new_state;
                if (!head_next[aidx].vld)
                begin
                    ready_next[aidx] = 1'b0;
                end
            end
        end

        if (do_append)
        begin
            tl            = tail_next[aidx];
            lnext_next[t] = NIL;
            if (head_next[aidx].vld && tl.vld)
            begin
                lprev_next[t]     = tl;
                lnext_next[tl.id] = '{vld: 1'b1, id: t};
            end
            else
            begin
                lprev_next[t]   = NIL;
                head_next[aidx] = '{vld: 1'b1, id: t};
            end
            tail_next[aidx]  = '{vld: 1'b1, id: t};
            queued_next[t]   = item_reg.thread_priority;
            ready_next[aidx] = 1'b1;
        end

        result_next.run_id          = cur_vld_next ? thread_id_t'(cur_next) : '0;
        result_next.run_valid       = cur_vld_next;
        result_next.switched        = sw;
        result_next.preempted_id    = pre ? thread_id_t'(pre_id) : '0;
        result_next.preempted_valid = pre;
        result_next.ready_map       = ready_map_t'(ready_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg   <= 1'b0;
            result_vld_reg <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                item_vld_reg <= 1'b1;
            end
            else if (fire)
            begin
                item_vld_reg <= 1'b0;
            end

            if (fire)
            begin
                result_vld_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg    <= '0;
            cur_reg      <= '0;
            cur_vld_reg  <= 1'b0;
            cur_prio_reg <= '0;
            for (int i = 0; i < NUM_PRIO; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                lnext_reg[i]  <= NIL;
                lprev_reg[i]  <= NIL;
                queued_reg[i] <= '0;
                status_reg[i] <= ST_INACTIVE;
            end
        end
        else if (fire)
        begin
            ready_reg    <= ready_next;
            cur_reg      <= cur_next;
            cur_vld_reg  <= cur_vld_next;
            cur_prio_reg <= cur_prio_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            lnext_reg    <= lnext_next;
            lprev_reg    <= lprev_next;
            queued_reg   <= queued_next;
            status_reg   <= status_next;
        end
    end

endmodule
